### sv/slcfr_pkg.sv
// ----------------------------------------------------------------------------
// slcfr_pkg
// Types and constants shared by the frame receiver modules.
// ----------------------------------------------------------------------------
package slcfr_pkg;

  // configuration register indexes
  localparam logic [7:0] REG_SYNC_FIRST     = 8'd0;
  localparam logic [7:0] REG_SYNC_SECOND    = 8'd1;
  localparam logic [7:0] REG_FUNCTION_LIMIT = 8'd2;
  localparam logic [7:0] REG_MAX_PAYLOAD    = 8'd3;

  // reset values of the configuration registers
  localparam logic [7:0] SYNC_FIRST_RST     = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RST    = 8'hAF;
  localparam logic [7:0] FUNCTION_LIMIT_RST = 8'hF1;
  localparam logic [5:0] MAX_PAYLOAD_RST    = 6'd49;

  // function codes that want an acknowledgment
  localparam logic [7:0] ACK_FUNC_LO = 8'h10;
  localparam logic [7:0] ACK_FUNC_HI = 8'h15;

  localparam int TDATA_W = 32;

  typedef enum logic [2:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_FUNC,
    PH_LEN,
    PH_DATA,
    PH_SUM
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_SHOW
  } back_state_t;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] function_limit;
    logic [5:0] max_payload;
  } cfg_t;

  // one checked frame waiting to be drained
  typedef struct packed {
    logic [7:0] function_code;
    logic [5:0] count;
    logic [7:0] frame_sum;
  } frame_desc_t;

endpackage

### sv/sync_length_checksum_frame_receiver.sv
// ----------------------------------------------------------------------------
// sync_length_checksum_frame_receiver
// Two-byte sync, length-prefixed frame receiver with an 8-bit additive sum.
// ----------------------------------------------------------------------------
// Received bytes are taken one per cycle while fewer than two checked frames
// wait to be drained; with both payload banks of the RAM taken, s_tready drops
// until the older frame has gone out. Each payload byte of a good frame is
// delivered as one transfer; the drain passes each byte through a registered
// RAM read, then the output stage, and fetches the next byte only after the
// current transfer is taken. Each frame's drain starts from the idle state.
// Frames with a bad header or checksum are dropped without any transfer.
// Configuration is always ready and should be written while the block is idle.
module sync_length_checksum_frame_receiver
  import slcfr_pkg::*;
#(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // rx_byte
  output logic               m_tvalid,
  input  logic               m_tready,
  // function_code, payload_byte, byte_index, frame_sum, zero padding
  output logic [TDATA_W-1:0] m_tdata,
  output logic               m_tlast,   // last_byte
  output logic               m_tuser    // ack_request
);

  localparam int AW = $clog2(2*BUFFER_DEPTH);

  cfg_t        cfg;
  logic        q_full, q_empty, push, pop;
  frame_desc_t push_desc, head;
  logic        ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]  ram_wdata, ram_rdata;
  logic [7:0]  function_code, payload_byte, frame_sum;
  logic [5:0]  byte_index;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first     <= SYNC_FIRST_RST;
      cfg.sync_second    <= SYNC_SECOND_RST;
      cfg.function_limit <= FUNCTION_LIMIT_RST;
      cfg.max_payload    <= MAX_PAYLOAD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SYNC_FIRST:     cfg.sync_first     <= cfg_data;
        REG_SYNC_SECOND:    cfg.sync_second    <= cfg_data;
        REG_FUNCTION_LIMIT: cfg.function_limit <= cfg_data;
        REG_MAX_PAYLOAD:    cfg.max_payload    <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  slcfr_front #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  slcfr_ram #(.WIDTH(8), .DEPTH(2*BUFFER_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  slcfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  slcfr_back #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_empty       (q_empty),
    .pop           (pop),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .function_code (function_code),
    .payload_byte  (payload_byte),
    .byte_index    (byte_index),
    .last_byte     (m_tlast),
    .ack_request   (m_tuser),
    .frame_sum     (frame_sum)
  );

  assign m_tdata = {2'b00, frame_sum, byte_index, payload_byte, function_code};

endmodule

### sv/slcfr_ram.sv
// ----------------------------------------------------------------------------
// slcfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slcfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/slcfr_front.sv
// ----------------------------------------------------------------------------
// slcfr_front
// Byte parser: hunts sync, checks header and checksum, stores the payload.
// ----------------------------------------------------------------------------
module slcfr_front
  import slcfr_pkg::*;
#(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  cfg_t                              cfg,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,
  input  logic                              q_full,
  output logic                              push,
  output frame_desc_t                       push_desc,
  output logic                              ram_we,
  output logic [$clog2(2*BUFFER_DEPTH)-1:0] ram_waddr,
  output logic [7:0]                        ram_wdata
);

  localparam int AW = $clog2(2*BUFFER_DEPTH);

  phase_t     phase, phase_next;
  logic [5:0] remaining_count, remaining_count_next;
  logic [5:0] stored_count, stored_count_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] held_function, held_function_next;
  logic       wr_bank, wr_bank_next;
  logic       accept;
  logic [7:0] sum_add;

  // two frames waiting means both payload banks are taken
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign sum_add  = running_sum + s_tdata;

  assign ram_wdata = s_tdata;
  assign ram_waddr = wr_bank ? AW'(BUFFER_DEPTH + int'(stored_count))
                             : AW'(int'(stored_count));

  assign push_desc.function_code = held_function;
  assign push_desc.count         = stored_count;
  assign push_desc.frame_sum     = running_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SYNC1;
      remaining_count <= '0;
      stored_count    <= '0;
      running_sum     <= '0;
      held_function   <= '0;
      wr_bank         <= 1'b0;
    end else begin
      phase           <= phase_next;
      remaining_count <= remaining_count_next;
      stored_count    <= stored_count_next;
      running_sum     <= running_sum_next;
      held_function   <= held_function_next;
      wr_bank         <= wr_bank_next;
    end
  end

  always_comb begin
    phase_next           = phase;
    remaining_count_next = remaining_count;
    stored_count_next    = stored_count;
    running_sum_next     = running_sum;
    held_function_next   = held_function;
    wr_bank_next         = wr_bank;
    ram_we               = 1'b0;
    push                 = 1'b0;
    if (accept) begin
      case (phase)
        PH_SYNC1: begin
          if (s_tdata == cfg.sync_first) begin
            running_sum_next = s_tdata;
            phase_next       = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          if (s_tdata == cfg.sync_second) begin
            running_sum_next = sum_add;
            phase_next       = PH_FUNC;
          end else begin
            phase_next = PH_SYNC1;
          end
        end
        PH_FUNC: begin
          if (s_tdata < cfg.function_limit) begin
            running_sum_next   = sum_add;
            held_function_next = s_tdata;
            phase_next         = PH_LEN;
          end else begin
            phase_next = PH_SYNC1;
          end
        end
        PH_LEN: begin
          if (s_tdata <= {2'b00, cfg.max_payload}) begin
            running_sum_next     = sum_add;
            remaining_count_next = s_tdata[5:0];
            stored_count_next    = '0;
            phase_next           = PH_DATA;
          end else begin
            phase_next = PH_SYNC1;
          end
        end
        PH_DATA: begin
          // a zero length lands here with nothing to take: back to hunting
          if (remaining_count != 6'd0) begin
            running_sum_next     = sum_add;
            ram_we               = int'(stored_count) < BUFFER_DEPTH;
            stored_count_next    = stored_count + 6'd1;
            remaining_count_next = remaining_count - 6'd1;
            if (remaining_count == 6'd1) begin
              phase_next = PH_SUM;
            end
          end else begin
            phase_next = PH_SYNC1;
          end
        end
        PH_SUM: begin
          phase_next = PH_SYNC1;
          if (s_tdata == running_sum && stored_count != 6'd0) begin
            push         = 1'b1;
            wr_bank_next = !wr_bank;
          end
        end
        default: begin
          phase_next = PH_SYNC1;
        end
      endcase
    end
  end

endmodule

### sv/slcfr_queue.sv
// ----------------------------------------------------------------------------
// slcfr_queue
// Two-entry queue of checked frames between parser and drain.
// ----------------------------------------------------------------------------
module slcfr_queue
  import slcfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  frame_desc_t push_desc,
  input  logic        pop,
  output frame_desc_t head,
  output logic        empty,
  output logic        full
);

  frame_desc_t entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign head  = entry[rd_ptr];
  assign empty = count == 2'd0;
  assign full  = count == 2'd2;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

### sv/slcfr_back.sv
// ----------------------------------------------------------------------------
// slcfr_back
// Drain sequencer: reads the stored payload of the head frame and presents it.
// ----------------------------------------------------------------------------
module slcfr_back
  import slcfr_pkg::*;
#(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  frame_desc_t                       head,
  input  logic                              q_empty,
  output logic                              pop,
  output logic                              ram_re,
  output logic [$clog2(2*BUFFER_DEPTH)-1:0] ram_raddr,
  input  logic [7:0]                        ram_rdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [7:0]                        function_code,
  output logic [7:0]                        payload_byte,
  output logic [5:0]                        byte_index,
  output logic                              last_byte,
  output logic                              ack_request,
  output logic [7:0]                        frame_sum
);

  localparam int AW = $clog2(2*BUFFER_DEPTH);

  back_state_t state, state_next;
  logic [5:0]  idx, idx_next;
  logic        beyond, beyond_next;
  logic        rd_bank, rd_bank_next;
  logic        in_range;

  assign in_range  = int'(idx) < BUFFER_DEPTH;
  assign ram_raddr = rd_bank ? AW'(BUFFER_DEPTH + int'(idx)) : AW'(int'(idx));

  assign m_tvalid      = state == BK_SHOW;
  assign function_code = head.function_code;
  assign frame_sum     = head.frame_sum;
  assign byte_index    = idx;
  // positions past the store read as zero
  assign payload_byte  = beyond ? 8'd0 : ram_rdata;
  assign last_byte     = (idx + 6'd1) == head.count;
  assign ack_request   = last_byte && head.function_code >= ACK_FUNC_LO
                         && head.function_code <= ACK_FUNC_HI;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_IDLE;
      idx     <= '0;
      beyond  <= 1'b0;
      rd_bank <= 1'b0;
    end else begin
      state   <= state_next;
      idx     <= idx_next;
      beyond  <= beyond_next;
      rd_bank <= rd_bank_next;
    end
  end

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    beyond_next  = beyond;
    rd_bank_next = rd_bank;
    ram_re       = 1'b0;
    pop          = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          idx_next   = '0;
          state_next = BK_FETCH;
        end
      end
      BK_FETCH: begin
        ram_re      = in_range;
        beyond_next = !in_range;
        state_next  = BK_SHOW;
      end
      BK_SHOW: begin
        if (m_tready) begin
          if (last_byte) begin
            pop          = 1'b1;
            rd_bank_next = !rd_bank;
            state_next   = BK_IDLE;
          end else begin
            idx_next   = idx + 6'd1;
            state_next = BK_FETCH;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

endmodule

### sv/slcfr_checker.sv
// ----------------------------------------------------------------------------
// slcfr_checker
// Port-level checks on the result stream of the frame receiver.
// ----------------------------------------------------------------------------
module slcfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  // a stalled transfer holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // acknowledgment only on the closing byte
  a_ack_on_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("ack request away from last byte");

  // a first byte has index zero once the previous frame closed
  a_first_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> !m_tvalid || m_tdata[21:16] == 6'd0)
    else $error("frame did not start at index zero");

  // nothing is presented straight after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind sync_length_checksum_frame_receiver slcfr_checker u_slcfr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
